// ----- hw/rtl/assert_macros.svh -----
// assertion macros for the rtl of the line stepper, included by its top level
// expects signals named clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge, off while in reset
`define LRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence checked in the cycle after the antecedent
`define LRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lrs_pkg.sv -----
// shared types and constants for the bresenham line stepper
// no dependencies
`timescale 1ns / 1ps

package lrs_pkg;

    localparam int COORD_BITS = 16;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int DIM_BITS   = 15;
    localparam int RGBA_BITS  = 32;
    localparam int CFG_IDX_BITS = 1;
    localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

    localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RESET  = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RESET = DIM_BITS'(480);

    // action codes
    localparam logic ACTION_LOAD    = 1'b0;
    localparam logic ACTION_ADVANCE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_HEIGHT = CFG_IDX_BITS'(1);

    // walking state of one line
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cursor_x;
        logic signed [COORD_BITS-1:0] cursor_y;
        logic signed [COORD_BITS-1:0] target_x;
        logic signed [COORD_BITS-1:0] target_y;
        logic        [DELTA_BITS-1:0] delta_x_abs;
        logic        [DELTA_BITS-1:0] delta_y_abs;
        logic                         step_x_negative;
        logic                         step_y_negative;
        logic signed [ERR_BITS-1:0]   error_term;
    } line_state_t;

    // per-pixel flags
    typedef struct packed {
        logic inside_frame;
        logic final_pixel;
    } pixel_flags_t;

endpackage

// ----- hw/rtl/lrs_setup.sv -----
// load setup: deltas, step signs and initial error term from two endpoints
// depends on lrs_pkg
`timescale 1ns / 1ps

module lrs_setup (
    input  logic signed [lrs_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] finish_x,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] finish_y,
    output lrs_pkg::line_state_t                  setup_state
);
    import lrs_pkg::*;

    logic signed [DELTA_BITS-1:0] delta_x;
    logic signed [DELTA_BITS-1:0] delta_y;
    logic        [DELTA_BITS-1:0] abs_x;
    logic        [DELTA_BITS-1:0] abs_y;

    assign delta_x = DELTA_BITS'(finish_x) - DELTA_BITS'(start_x);
    assign delta_y = DELTA_BITS'(finish_y) - DELTA_BITS'(start_y);
    assign abs_x   = delta_x[DELTA_BITS-1] ? unsigned'(-delta_x) : unsigned'(delta_x);
    assign abs_y   = delta_y[DELTA_BITS-1] ? unsigned'(-delta_y) : unsigned'(delta_y);

    always_comb
    begin
        setup_state.cursor_x        = start_x;
        setup_state.cursor_y        = start_y;
        setup_state.target_x        = finish_x;
        setup_state.target_y        = finish_y;
        setup_state.delta_x_abs     = abs_x;
        setup_state.delta_y_abs     = abs_y;
        setup_state.step_x_negative = !(start_x < finish_x);
        setup_state.step_y_negative = !(start_y < finish_y);
        // half the major delta, negative when y dominates or the deltas tie
        if (abs_x > abs_y)
        begin
            setup_state.error_term = signed'(ERR_BITS'(abs_x >> 1));
        end
        else
        begin
            setup_state.error_term = -signed'(ERR_BITS'(abs_y >> 1));
        end
    end

endmodule

// ----- hw/rtl/lrs_step.sv -----
// one bresenham step: error decision and cursor move
// depends on lrs_pkg
`timescale 1ns / 1ps

module lrs_step (
    input  lrs_pkg::line_state_t cur_state,
    output lrs_pkg::line_state_t step_state
);
    import lrs_pkg::*;

    logic signed [ERR_BITS-1:0] dx_ext;
    logic signed [ERR_BITS-1:0] dy_ext;
    logic                       move_x;
    logic                       move_y;

    assign dx_ext = signed'(ERR_BITS'(cur_state.delta_x_abs));
    assign dy_ext = signed'(ERR_BITS'(cur_state.delta_y_abs));
    assign move_x = cur_state.error_term > -dx_ext;
    assign move_y = cur_state.error_term < dy_ext;

    always_comb
    begin
        step_state = cur_state;
        step_state.error_term = cur_state.error_term
                              - (move_x ? dy_ext : ERR_BITS'(0))
                              + (move_y ? dx_ext : ERR_BITS'(0));
        if (move_x)
        begin
            step_state.cursor_x = cur_state.step_x_negative
                                ? cur_state.cursor_x - COORD_BITS'(1)
                                : cur_state.cursor_x + COORD_BITS'(1);
        end
        if (move_y)
        begin
            step_state.cursor_y = cur_state.step_y_negative
                                ? cur_state.cursor_y - COORD_BITS'(1)
                                : cur_state.cursor_y + COORD_BITS'(1);
        end
    end

endmodule

// ----- hw/rtl/lrs_emit.sv -----
// pixel flags: frame clipping test and end-of-line match
// depends on lrs_pkg
`timescale 1ns / 1ps

module lrs_emit (
    input  logic signed [lrs_pkg::COORD_BITS-1:0] cursor_x,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] cursor_y,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] target_x,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] target_y,
    input  logic        [lrs_pkg::DIM_BITS-1:0]   frame_width,
    input  logic        [lrs_pkg::DIM_BITS-1:0]   frame_height,
    output lrs_pkg::pixel_flags_t                 flags
);
    import lrs_pkg::*;

    logic [CMP_BITS-1:0] x_cmp;
    logic [CMP_BITS-1:0] y_cmp;

    // sign is tested apart, so plain zero extension is enough here
    assign x_cmp = CMP_BITS'(unsigned'(cursor_x));
    assign y_cmp = CMP_BITS'(unsigned'(cursor_y));

    always_comb
    begin
        flags.inside_frame = !cursor_x[COORD_BITS-1] && !cursor_y[COORD_BITS-1]
                           && (x_cmp < CMP_BITS'(frame_width))
                           && (y_cmp < CMP_BITS'(frame_height));
        flags.final_pixel  = (cursor_x == target_x) && (cursor_y == target_y);
    end

endmodule

// ----- hw/rtl/line_rasterizer_stepper.sv -----
// line_rasterizer_stepper: top level of the bresenham line stepper
// the step logic feeds the line state register directly; a pixel word appears
// in the cycle after its item is taken; one item per cycle unless the output stalls
// reset: async active low; no line in progress, frame 640 x 480, output empty
// depends on lrs_pkg, lrs_setup, lrs_step, lrs_emit and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module line_rasterizer_stepper (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write port
    input  logic                                  cfg_write_en,
    input  logic [lrs_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [lrs_pkg::DIM_BITS-1:0]          cfg_data,
    // input word channel
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  logic                                  action,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] start_x,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] start_y,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] finish_x,
    input  logic signed [lrs_pkg::COORD_BITS-1:0] finish_y,
    input  logic [lrs_pkg::RGBA_BITS-1:0]         line_rgba,
    // pixel word channel
    output logic                                  pixel_valid,
    input  logic                                  pixel_ready,
    output logic signed [lrs_pkg::COORD_BITS-1:0] pixel_x,
    output logic signed [lrs_pkg::COORD_BITS-1:0] pixel_y,
    output logic [lrs_pkg::RGBA_BITS-1:0]         pixel_rgba,
    output logic                                  inside_frame,
    output logic                                  final_pixel
);
    import lrs_pkg::*;

    // configuration registers
    logic [DIM_BITS-1:0] frame_width_reg;
    logic [DIM_BITS-1:0] frame_height_reg;

    // line state; the line is live while loaded and the cursor is short of the target
    line_state_t          line_reg;
    line_state_t          line_next;
    logic                 loaded_reg;
    logic                 loaded_next;
    logic [RGBA_BITS-1:0] rgba_reg;
    logic [RGBA_BITS-1:0] rgba_next;
    logic                 line_active;

    // output word register
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [COORD_BITS-1:0] out_x_reg;
    logic signed [COORD_BITS-1:0] out_y_reg;
    logic [RGBA_BITS-1:0]         out_rgba_reg;
    pixel_flags_t                 out_flags_reg;

    line_state_t  setup_state;
    line_state_t  step_state;
    pixel_flags_t flags;
    logic         item_fire;
    logic         is_load;
    logic         emits;

    lrs_setup u_setup (
        .start_x     (start_x),
        .start_y     (start_y),
        .finish_x    (finish_x),
        .finish_y    (finish_y),
        .setup_state (setup_state)
    );

    lrs_step u_step (
        .cur_state  (line_reg),
        .step_state (step_state)
    );

    // flags are taken from the pixel about to be registered
    lrs_emit u_emit (
        .cursor_x     (line_next.cursor_x),
        .cursor_y     (line_next.cursor_y),
        .target_x     (line_next.target_x),
        .target_y     (line_next.target_y),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .flags        (flags)
    );

    assign line_active = loaded_reg
                       && !((line_reg.cursor_x == line_reg.target_x)
                            && (line_reg.cursor_y == line_reg.target_y));

    // take a new word whenever the output slot is free or draining this cycle
    assign item_ready = !out_valid_reg || pixel_ready;
    assign item_fire  = item_valid && item_ready;
    assign is_load    = (action == ACTION_LOAD);
    // a load always gives a pixel, an advance only while the line is live
    assign emits      = item_fire && (is_load || line_active);

    always_comb
    begin
        line_next   = line_reg;
        loaded_next = loaded_reg;
        rgba_next   = rgba_reg;
        if (item_fire && is_load)
        begin
            line_next   = setup_state;
            loaded_next = 1'b1;
            rgba_next   = line_rgba;
        end
        else if (emits)
        begin
            line_next = step_state;
        end
    end

    always_comb
    begin
        if (emits)
        begin
            out_valid_next = 1'b1;
        end
        else if (pixel_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
            line_reg         <= '0;
            loaded_reg       <= 1'b0;
            rgba_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                    default:          ;
                endcase
            end
            line_reg      <= line_next;
            loaded_reg    <= loaded_next;
            rgba_reg      <= rgba_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, loaded only with a new pixel
    always_ff @(posedge clk)
    begin
        if (emits)
        begin
            out_x_reg     <= line_next.cursor_x;
            out_y_reg     <= line_next.cursor_y;
            out_rgba_reg  <= rgba_next;
            out_flags_reg <= flags;
        end
    end

    assign pixel_valid  = out_valid_reg;
    assign pixel_x      = out_x_reg;
    assign pixel_y      = out_y_reg;
    assign pixel_rgba   = out_rgba_reg;
    assign inside_frame = out_flags_reg.inside_frame;
    assign final_pixel  = out_flags_reg.final_pixel;

    // a load always produces a pixel at its start point
    `LRS_ASSERT_NEXT(a_load_emits, item_fire && is_load,
        pixel_valid && pixel_x == $past(start_x) && pixel_y == $past(start_y),
        "load did not emit its start pixel")
    // a pending final pixel means the line has ended
    `LRS_ASSERT_IMPL(a_final_ends_line, pixel_valid && final_pixel, !line_active,
        "line still live behind a final pixel")
    // an advance with no live line leaves the cursor alone
    `LRS_ASSERT_NEXT(a_idle_advance_holds, item_fire && !is_load && !line_active,
        $stable(line_reg.cursor_x) && $stable(line_reg.cursor_y),
        "advance moved the cursor with no line live")
    // every step of a live line moves the cursor
    `LRS_ASSERT_NEXT(a_step_moves, item_fire && !is_load && line_active,
        !($stable(line_reg.cursor_x) && $stable(line_reg.cursor_y)),
        "advance of a live line did not move the cursor")

endmodule
